// ===== src/dense_layer_threshold_matvec_assert.svh =====
// ----------------------------------------------------------------------------
// Dense layer threshold matvec assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_THRESHOLD_MATVEC_ASSERT_SVH
`define DENSE_LAYER_THRESHOLD_MATVEC_ASSERT_SVH

// same-cycle implication
`define DLTM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dltm port check failed");

// next-cycle implication
`define DLTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dltm port check failed");

`endif

// ===== src/dltm_pkg.sv =====
// ----------------------------------------------------------------------------
// Dense layer threshold matvec package
// Sizes, field widths, codes and saturation shared by the block and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dltm_pkg;

   localparam int MAX_ROWS     = 8;
   localparam int MAX_INPUTS   = 16;
   localparam int COLS_PER_ROW = MAX_INPUTS + 1;
   localparam int WSTORE_DEPTH = MAX_ROWS * COLS_PER_ROW;
   localparam int WADDR_W      = $clog2(WSTORE_DEPTH);

   localparam int ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int STEP_W     = $clog2(MAX_ROWS + 2);
   localparam int ELEM_W     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int IN_CNT_W   = $clog2(MAX_INPUTS + 1);

   localparam int WROW_W      = 3;
   localparam int WCOL_W      = 5;
   localparam int VALUE_W     = 16;
   localparam int OUT_ROW_W   = 3;
   localparam int OUT_VALUE_W = 40;
   localparam int ACC_W       = 40;
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int THR_SHIFT   = 12;

   localparam int ROWS_CFG_W   = 4;
   localparam int INPUTS_CFG_W = 5;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 5;

   localparam logic [ROWS_CFG_W-1:0]   ROWS_RESET   = 4'd8;
   localparam logic [INPUTS_CFG_W-1:0] INPUTS_RESET = 5'd16;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_IN_USE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUTS_IN_USE = 1'b1;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_FEED  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT
   } state_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
      logic signed [ACC_W-1:0] res;
      if (v[ACC_W] != v[ACC_W-1]) begin
         res = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         res = v[ACC_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/dltm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dltm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 136,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/dense_layer_threshold_matvec.sv =====
// ----------------------------------------------------------------------------
// Dense layer threshold matvec
// Fully connected layer forward pass over one input column, with a per-row
// threshold subtracted and the result saturated to signed Q16.24 in 40 bits.
// ----------------------------------------------------------------------------
// A weight write (req_cmd = 0) is taken while busy stays low. A feed
// (req_cmd = 1) holds busy while the element runs through the weight RAM
// read port and the one shared multiplier and accumulator, one row per
// cycle. A feed that completes the column then holds busy through a further
// pass over the rows, reading each row threshold from the same RAM port; the
// results then leave one per cycle on rsp_strobe, rows in ascending order,
// rsp_last on the final row. The receiver cannot stall, so every strobed
// result must be taken in its cycle. Weights must be written before they
// are used; an unwritten weight word reads as garbage.
`default_nettype none

module dense_layer_threshold_matvec (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_cmd,
   input  logic [dltm_pkg::WROW_W-1:0]              req_weight_row,
   input  logic [dltm_pkg::WCOL_W-1:0]              req_weight_col,
   input  logic signed [dltm_pkg::VALUE_W-1:0]      req_value,
   output logic                                     rsp_strobe,
   output logic [dltm_pkg::OUT_ROW_W-1:0]           rsp_out_row,
   output logic signed [dltm_pkg::OUT_VALUE_W-1:0]  rsp_out_value,
   output logic                                     rsp_last,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [dltm_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [dltm_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   import dltm_pkg::*;

   state_type                   state_ff, state_in;
   logic [ROWS_CFG_W-1:0]       rows_cfg_ff;
   logic [INPUTS_CFG_W-1:0]     inputs_cfg_ff;
   logic [ROW_CNT_W-1:0]        rows_ff;
   logic [ELEM_W-1:0]           elem_ff;
   logic [ELEM_W-1:0]           ec_ff;
   logic                        col_end_ff;
   logic signed [VALUE_W-1:0]   value_ff;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        s1_vld_ff;
   logic [ROW_IDX_W-1:0]        s1_row_ff;
   logic                        s2_vld_ff;
   logic [ROW_IDX_W-1:0]        s2_row_ff;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff [MAX_ROWS];
   logic                        out_strobe_ff;
   logic [OUT_ROW_W-1:0]        out_row_ff;
   logic signed [ACC_W-1:0]     out_value_ff, out_value_in;
   logic                        out_last_ff;

   logic                        accept;
   logic                        feed_go;
   logic                        wr_go;
   logic [ROW_CNT_W-1:0]        rows_use;
   logic [IN_CNT_W-1:0]         inputs_use;
   logic [IN_CNT_W-1:0]         ec_next_cnt;
   logic                        col_end;
   logic                        issue_vld;
   logic [ROW_IDX_W-1:0]        issue_row;
   logic                        mac_done;
   logic                        emit_done;
   logic [WADDR_W-1:0]          rd_addr;
   logic [WADDR_W-1:0]          wr_addr;
   logic signed [VALUE_W-1:0]   w_rdata;
   logic [ROW_IDX_W-1:0]        acc_idx;
   logic signed [ACC_W-1:0]     acc_rd;
   logic signed [ACC_W:0]       thr_ext;
   logic signed [ACC_W-1:0]     acc_sum;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign feed_go   = accept && (req_cmd == CMD_FEED);
   assign wr_go     = accept && (req_cmd == CMD_WRITE)
                      && (int'(req_weight_row) < MAX_ROWS)
                      && (int'(req_weight_col) <= MAX_INPUTS);

   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_use = ROW_CNT_W'(1);
      end else if (int'(rows_cfg_ff) > MAX_ROWS) begin
         rows_use = ROW_CNT_W'(MAX_ROWS);
      end else begin
         rows_use = ROW_CNT_W'(rows_cfg_ff);
      end
      if (inputs_cfg_ff == '0) begin
         inputs_use = IN_CNT_W'(1);
      end else if (int'(inputs_cfg_ff) > MAX_INPUTS) begin
         inputs_use = IN_CNT_W'(MAX_INPUTS);
      end else begin
         inputs_use = IN_CNT_W'(inputs_cfg_ff);
      end
   end

   assign ec_next_cnt = IN_CNT_W'(ec_ff) + IN_CNT_W'(1);
   assign col_end     = (ec_next_cnt >= inputs_use);

   // sequencer outputs
   always_comb begin
      issue_vld = ((state_ff == ST_MAC) || (state_ff == ST_EMIT))
                  && (step_ff < STEP_W'(rows_ff));
      issue_row = ROW_IDX_W'(step_ff);
      mac_done  = (state_ff == ST_MAC) && (step_ff == STEP_W'(rows_ff) + STEP_W'(1));
      emit_done = (state_ff == ST_EMIT) && (step_ff == STEP_W'(rows_ff));
      rd_addr   = WADDR_W'(issue_row) * WADDR_W'(COLS_PER_ROW);
      if (state_ff == ST_MAC) begin
         rd_addr = rd_addr + WADDR_W'(elem_ff) + WADDR_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (feed_go) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               state_in = col_end_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign step_in = (state_in != state_ff) ? '0 : (step_ff + STEP_W'(1));

   assign wr_addr = WADDR_W'(req_weight_row) * WADDR_W'(COLS_PER_ROW)
                    + WADDR_W'(req_weight_col);

   dltm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (WSTORE_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wr_go),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (issue_vld),
      .rd_addr (rd_addr),
      .rd_data (w_rdata)
   );

   assign acc_idx = (state_ff == ST_EMIT) ? s1_row_ff : s2_row_ff;
   assign acc_rd  = acc_ff[acc_idx];
   assign prod_in = w_rdata * value_ff;
   assign acc_sum = sat_acc((ACC_W+1)'(acc_rd) + (ACC_W+1)'(prod_ff));
   assign thr_ext = (ACC_W+1)'(w_rdata);
   assign out_value_in = sat_acc((ACC_W+1)'(acc_rd) - (thr_ext <<< THR_SHIFT));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         rows_cfg_ff   <= ROWS_RESET;
         inputs_cfg_ff <= INPUTS_RESET;
         ec_ff         <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         s1_vld_ff     <= issue_vld;
         s2_vld_ff     <= s1_vld_ff && (state_ff == ST_MAC);
         out_strobe_ff <= s1_vld_ff && (state_ff == ST_EMIT);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROWS_IN_USE:   rows_cfg_ff   <= csr_wdata[ROWS_CFG_W-1:0];
               REG_INPUTS_IN_USE: inputs_cfg_ff <= csr_wdata[INPUTS_CFG_W-1:0];
               default: begin
               end
            endcase
         end
         if (feed_go) begin
            ec_ff <= col_end ? '0 : ELEM_W'(ec_next_cnt);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (feed_go) begin
         rows_ff    <= rows_use;
         elem_ff    <= ec_ff;
         col_end_ff <= col_end;
         value_ff   <= req_value;
      end
      s1_row_ff    <= issue_row;
      s2_row_ff    <= s1_row_ff;
      prod_ff      <= prod_in;
      out_row_ff   <= OUT_ROW_W'(s1_row_ff);
      out_value_ff <= out_value_in;
      out_last_ff  <= (ROW_CNT_W'(s1_row_ff) == rows_ff - ROW_CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            acc_ff[r] <= '0;
         end
      end else if (feed_go && (ec_ff == '0)) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            acc_ff[r] <= '0;
         end
      end else if (s2_vld_ff) begin
         acc_ff[s2_row_ff] <= acc_sum;
      end
   end

   assign rsp_strobe    = out_strobe_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_value = OUT_VALUE_W'(out_value_ff);
   assign rsp_last      = out_last_ff;

endmodule

`default_nettype wire

// ===== src/dltm_checker.sv =====
// ----------------------------------------------------------------------------
// Dense layer threshold matvec port checker
// Watches the ports for busy and result ordering over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dense_layer_threshold_matvec_assert.svh"

module dltm_port_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_cmd,
   input  logic                            rsp_strobe,
   input  logic [dltm_pkg::OUT_ROW_W-1:0]  rsp_out_row,
   input  logic                            rsp_last
);

   import dltm_pkg::*;

   `DLTM_ASSERT_NEXT(a_write_no_busy, clock, reset,
      start && !busy && (req_cmd == CMD_WRITE), !busy)

   `DLTM_ASSERT_NEXT(a_feed_busy, clock, reset,
      start && !busy && (req_cmd == CMD_FEED), busy)

   `DLTM_ASSERT_NEXT(a_rows_back_to_back, clock, reset,
      rsp_strobe && !rsp_last, rsp_strobe)

   `DLTM_ASSERT_NEXT(a_row_advance, clock, reset,
      rsp_strobe && !rsp_last, rsp_out_row == OUT_ROW_W'($past(rsp_out_row) + 1'b1))

   `DLTM_ASSERT_SAME(a_first_row_zero, clock, reset,
      rsp_strobe && !$past(rsp_strobe), rsp_out_row == '0)

endmodule

bind dense_layer_threshold_matvec dltm_port_checker u_dltm_checker (.*);

`default_nettype wire
